// File: src/datm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// datm_pkg: shared types and constants of the daily alarm table matcher
// Request and result payloads, the token passed along the cell row, the
// per-cell write and response groups, and the minute-of-day helper.
// ----------------------------------------------------------------------------
package datm_pkg;

	localparam int MIN_W     = 11;
	localparam int AMT_W     = 8;
	localparam int IDX_W     = 3;
	localparam int CNT_W     = 4;
	localparam int OFF_W     = 12;
	localparam int MAX_FIRED = 8;

	localparam logic [MIN_W-1:0] MIN_PER_DAY = 11'd1440;

	// opcodes
	localparam logic OP_TICK  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	// configuration register indexes
	localparam logic [0:0] REG_UTC_OFFSET  = 1'b0;
	localparam logic [0:0] REG_ENTRY_COUNT = 1'b1;

	typedef struct packed {
		logic             opcode;
		logic             time_synced;
		logic [4:0]       utc_hour;
		logic [5:0]       utc_minute;
		logic [IDX_W-1:0] slot_index;
		logic [4:0]       slot_hour;
		logic [5:0]       slot_minute;
		logic [AMT_W-1:0] slot_amount;
	} in_item_t;

	typedef struct packed {
		logic [IDX_W-1:0] fired_index;
		logic [AMT_W-1:0] fired_amount;
		logic             last_of_run;
	} out_item_t;

	typedef struct packed {
		logic             vld;
		logic [MIN_W-1:0] minute;
	} tok_t;

	typedef struct packed {
		logic             wen;
		logic             clr;
		logic [MIN_W-1:0] at;
		logic [AMT_W-1:0] amount;
	} cell_wr_t;

	typedef struct packed {
		logic             hit;
		logic [AMT_W-1:0] amount;
	} cell_rsp_t;

	// hour*60 + minute, out-of-range inputs used as they come (max 1923)
	function automatic logic [MIN_W-1:0] minute_of_day(input logic [4:0] hour,
			input logic [5:0] minute);
		return {hour, 6'b0} - {4'b0, hour, 2'b0} + {5'b0, minute};
	endfunction

endpackage
`default_nettype wire

// File: src/datm_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// datm_cell: one alarm table slot
// Holds the slot's minute of day, amount and fired mark. A tick token moves
// through one cell per shift; the cell holding it reports a match.
// ----------------------------------------------------------------------------
module datm_cell
	import datm_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire cell_wr_t  wr,
	input  wire logic      en,
	input  wire logic      shift,
	input  wire tok_t      tok_in,
	output tok_t           tok_out,
	output cell_rsp_t      rsp
);

	logic [MIN_W-1:0] at_q;
	logic [AMT_W-1:0] amt_q;
	logic             fv_q;
	logic [MIN_W-1:0] fm_q;
	logic             tok_vld_q;
	logic [MIN_W-1:0] tok_min_q;
	logic             match;

	assign match = tok_vld_q && (at_q == tok_min_q) && !(fv_q && (fm_q == tok_min_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			at_q      <= '0;
			amt_q     <= '0;
			fv_q      <= 1'b0;
			tok_vld_q <= 1'b0;
		end else begin
			if (wr.wen) begin
				at_q  <= wr.at;
				amt_q <= wr.amount;
			end
			if (wr.clr) begin
				fv_q <= 1'b0;
			end else if (match && shift) begin
				fv_q <= 1'b1;
			end
			if (shift) begin
				tok_vld_q <= tok_in.vld && en;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (match && shift) begin
			fm_q <= tok_min_q;
		end
		if (shift) begin
			tok_min_q <= tok_in.minute;
		end
	end

	assign tok_out.vld    = tok_vld_q;
	assign tok_out.minute = tok_min_q;
	assign rsp.hit        = match;
	assign rsp.amount     = amt_q;

endmodule
`default_nettype wire

// File: src/daily_alarm_table_matcher.sv
`timescale 1ns / 1ps
`default_nettype none
// Write, unsynced tick, tick with count zero: next request taken in the next cycle.
// Synced tick: local minute in ST_CALC, then ST_WALK moves one slot per shift through
// the slots in use (entry_count capped at min(TABLE_DEPTH, 8)) as the token walks the
// cell row, then ST_FLUSH loads the last result, if any; ST_WALK and ST_FLUSH wait
// while the result register is stalled, and the next request is taken back in ST_IDLE.
// Reset: table zero, no fired marks, offset and count zero, no result pending.
// ----------------------------------------------------------------------------
// daily_alarm_table_matcher: daily alarm table matched against time ticks
// A tick token walks a row of slot cells; each matching slot emits its index
// and amount once per minute, the last result of a tick flagged.
// ----------------------------------------------------------------------------
module daily_alarm_table_matcher
	import datm_pkg::*;
#(
	parameter int TABLE_DEPTH = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_write_en,
	input  wire logic [0:0]       cfg_index,
	input  wire logic [OFF_W-1:0] cfg_data,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire in_item_t         in_item,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output out_item_t             out_item
);

	localparam int NCELL = (TABLE_DEPTH < MAX_FIRED) ? TABLE_DEPTH : MAX_FIRED;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_CALC  = 2'd1;
	localparam logic [1:0] ST_WALK  = 2'd2;
	localparam logic [1:0] ST_FLUSH = 2'd3;

	localparam logic signed [OFF_W-1:0] OFF_DAY = 12'sd1440;
	localparam logic [12:0] DAY1 = 13'd1440;
	localparam logic [12:0] DAY2 = 13'd2880;
	localparam logic [12:0] DAY3 = 13'd4320;

	logic [1:0]              state_q;
	logic signed [OFF_W-1:0] offr_q;
	logic [CNT_W-1:0]        ecnt_q;
	logic [12:0]             sum_s1;
	logic [IDX_W-1:0]        pos_q;
	logic                    pend_v_q;
	logic [IDX_W-1:0]        pend_idx_q;
	logic [AMT_W-1:0]        pend_amt_q;
	logic                    out_v_q;
	out_item_t               out_q;

	logic                    accept;
	logic                    slot_ok;
	logic [CNT_W-1:0]        cnt_eff;
	logic [IDX_W-1:0]        last_pos;
	logic [13:0]             sum_now;
	logic [12:0]             day_sub;
	logic [12:0]             local_full;
	logic [MIN_W-1:0]        local_min;
	logic signed [OFF_W-1:0] off_rem;
	logic [MIN_W-1:0]        wr_at;
	logic                    hit_any;
	logic [AMT_W-1:0]        amt_any;
	logic                    out_free;
	logic                    adv;
	logic                    shift;
	logic                    load_walk;
	logic                    load_flush;

	cell_wr_t                wr   [NCELL];
	cell_rsp_t               rsp  [NCELL];
	tok_t                    tok  [NCELL];
	tok_t                    tok0;
	logic                    en   [NCELL];

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign slot_ok   = (32'(in_item.slot_index) < TABLE_DEPTH);
	assign cnt_eff   = (ecnt_q > CNT_W'(NCELL)) ? CNT_W'(NCELL) : ecnt_q;
	assign last_pos  = IDX_W'(cnt_eff - 4'd1);
	assign wr_at     = minute_of_day(in_item.slot_hour, in_item.slot_minute);

	// offset reduced toward zero into (-1440, 1440) at write time
	always_comb begin
		priority if (cfg_data >= OFF_DAY && !cfg_data[OFF_W-1]) begin
			off_rem = $signed(cfg_data) - OFF_DAY;
		end else if ($signed(cfg_data) <= -OFF_DAY) begin
			off_rem = $signed(cfg_data) + OFF_DAY;
		end else begin
			off_rem = $signed(cfg_data);
		end
	end

	assign sum_now = 14'(minute_of_day(in_item.utc_hour, in_item.utc_minute))
		+ {{2{offr_q[OFF_W-1]}}, offr_q} + 14'(DAY1);

	always_comb begin
		priority if (sum_s1 >= DAY3) begin
			day_sub = DAY3;
		end else if (sum_s1 >= DAY2) begin
			day_sub = DAY2;
		end else if (sum_s1 >= DAY1) begin
			day_sub = DAY1;
		end else begin
			day_sub = '0;
		end
	end
	assign local_full = sum_s1 - day_sub;
	assign local_min  = local_full[MIN_W-1:0];

	// at most one cell holds the token at a time
	always_comb begin
		hit_any = 1'b0;
		amt_any = '0;
		for (int k = 0; k < NCELL; k++) begin
			hit_any = hit_any | rsp[k].hit;
			amt_any = amt_any | (rsp[k].hit ? rsp[k].amount : '0);
		end
	end

	assign out_free   = !out_v_q || out_ready;
	assign adv        = !hit_any || !pend_v_q || out_free;
	assign shift      = (state_q == ST_CALC) || (state_q == ST_WALK && adv);
	assign load_walk  = (state_q == ST_WALK) && hit_any && pend_v_q && out_free;
	assign load_flush = (state_q == ST_FLUSH) && pend_v_q && out_free;

	assign tok0.vld    = (state_q == ST_CALC);
	assign tok0.minute = local_min;

	for (genvar k = 0; k < NCELL; k++) begin : g_cell
		assign en[k]        = (CNT_W'(k) < cnt_eff);
		assign wr[k].wen    = accept && (in_item.opcode == OP_WRITE) && slot_ok
			&& (32'(in_item.slot_index) == k);
		assign wr[k].clr    = accept && (in_item.opcode == OP_WRITE) && slot_ok;
		assign wr[k].at     = wr_at;
		assign wr[k].amount = in_item.slot_amount;

		datm_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.wr     (wr[k]),
			.en     (en[k]),
			.shift  (shift),
			.tok_in ((k == 0) ? tok0 : tok[(k == 0) ? 0 : k-1]),
			.tok_out(tok[k]),
			.rsp    (rsp[k])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offr_q <= '0;
			ecnt_q <= '0;
		end else if (cfg_write_en) begin
			unique case (cfg_index)
				REG_UTC_OFFSET: begin
					offr_q <= off_rem;
				end
				REG_ENTRY_COUNT: begin
					ecnt_q <= cfg_data[CNT_W-1:0];
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			pos_q    <= '0;
			pend_v_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept && in_item.opcode == OP_TICK && in_item.time_synced
							&& cnt_eff != '0) begin
						state_q <= ST_CALC;
					end
				end
				ST_CALC: begin
					pos_q   <= '0;
					state_q <= ST_WALK;
				end
				ST_WALK: begin
					if (adv) begin
						if (hit_any) begin
							pend_v_q <= 1'b1;
						end
						if (pos_q == last_pos) begin
							state_q <= ST_FLUSH;
						end else begin
							pos_q <= pos_q + 1'b1;
						end
					end
				end
				ST_FLUSH: begin
					if (!pend_v_q || out_free) begin
						pend_v_q <= 1'b0;
						state_q  <= ST_IDLE;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sum_s1 <= sum_now[12:0];
		end
		if (state_q == ST_WALK && adv && hit_any) begin
			pend_idx_q <= pos_q;
			pend_amt_q <= amt_any;
		end
		if (load_walk || load_flush) begin
			out_q.fired_index  <= pend_idx_q;
			out_q.fired_amount <= pend_amt_q;
			out_q.last_of_run  <= load_flush;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (load_walk || load_flush) begin
			out_v_q <= 1'b1;
		end else if (out_ready) begin
			out_v_q <= 1'b0;
		end
	end

	assign out_valid = out_v_q;
	assign out_item  = out_q;

endmodule
`default_nettype wire

// File: src/datm_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// datm_checker: port-level checks of the daily alarm table matcher
// Result channel stability and the request/result ordering seen at the ports.
// ----------------------------------------------------------------------------
module datm_checker
	import datm_pkg::*;
(
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      in_valid,
	input wire logic      in_ready,
	input wire in_item_t  in_item,
	input wire logic      out_valid,
	input wire logic      out_ready,
	input wire out_item_t out_item
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("result changed while stalled");

	// writes and unsynced ticks leave the input ready in the next cycle
	a_quick_req: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (in_item.opcode == OP_WRITE || !in_item.time_synced)
		|=> in_ready)
		else $error("short request did not release the input");

	// a new result only comes from a tick being worked on
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared while idle");

endmodule

bind daily_alarm_table_matcher datm_checker u_datm_checker (.*);
`default_nettype wire
